// ----- design/pol_pkg.sv -----
// Package with the shared types and codes of the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W = 5;
	localparam int KIND_W = 2;
	localparam int SIDE_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 5;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_BEFORE = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_AFTER = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADSIDE = 2'd3;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_READ
	} cell_op_t;

endpackage

// ----- design/pol_cell.sv -----
// One storage cell of the list: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module pol_cell
	import pol_pkg::*;
#(
	parameter int CW = 5,
	parameter logic [CW-1:0] IDX = '0
) (
	input  logic               clk,
	input  cell_op_t           op,
	input  logic [CW-1:0]      idx,
	input  logic [VALUE_W-1:0] load_value,
	input  logic [VALUE_W-1:0] left_value,
	input  logic [VALUE_W-1:0] right_value,
	output logic [VALUE_W-1:0] cur_value,
	output logic [VALUE_W-1:0] rd_word
);

	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] value_d;

	always_comb begin
		value_d = value_q;
		case (op)
			OP_INSERT: begin
				if (IDX > idx) begin
					value_d = left_value;
				end else if (IDX == idx) begin
					value_d = load_value;
				end
			end
			OP_DELETE: begin
				if (IDX >= idx) begin
					value_d = right_value;
				end
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign cur_value = value_q;
	assign rd_word = (op == OP_READ && idx == IDX) ? value_q : '0;

endmodule

// ----- design/pol_ctrl.sv -----
// Request decoder and entry counter of the positional ordered list.
`timescale 1ns / 1ps

module pol_ctrl
	import pol_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int CW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req,
	input  logic [KIND_W-1:0]   kind,
	input  logic [POS_W-1:0]    position,
	input  logic [SIDE_W-1:0]   placement,
	output cell_op_t            op,
	output logic [CW-1:0]       idx,
	output logic [STATUS_W-1:0] status,
	output logic [CW-1:0]       count,
	output logic [CW-1:0]       count_next
);

	localparam int EW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	logic [CW-1:0] count_q;
	logic [EW-1:0] pos_e;
	logic [EW-1:0] cnt_e;
	logic          pos_ok;

	assign pos_e = EW'(position);
	assign cnt_e = EW'(count_q);
	assign pos_ok = (pos_e != '0) && (pos_e <= cnt_e);

	always_comb begin
		op = OP_HOLD;
		idx = CW'(pos_e - EW'(1));
		status = ST_OK;
		count_next = count_q;
		if (req) begin
			case (kind)
				KIND_INSERT: begin
					if (count_q == FULL_COUNT) begin
						status = ST_FULL;
					end else if (count_q == '0) begin
						op = OP_INSERT;
						idx = '0;
						count_next = count_q + CW'(1);
					end else if (!pos_ok) begin
						status = ST_BADPOS;
					end else if (placement == SIDE_BEFORE) begin
						op = OP_INSERT;
						count_next = count_q + CW'(1);
					end else if (placement == SIDE_AFTER) begin
						op = OP_INSERT;
						idx = CW'(pos_e);
						count_next = count_q + CW'(1);
					end else begin
						status = ST_BADSIDE;
					end
				end
				KIND_DELETE: begin
					if (!pos_ok) begin
						status = ST_BADPOS;
					end else begin
						op = OP_DELETE;
						count_next = count_q - CW'(1);
					end
				end
				KIND_READ: begin
					if (!pos_ok) begin
						status = ST_BADPOS;
					end else begin
						op = OP_READ;
					end
				end
				default: status = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign count = count_q;

endmodule

// ----- design/positional_ordered_list.sv -----
// Top level of the positional ordered list: a row of shifting cells and a decoder.
`timescale 1ns / 1ps

// Keeps an ordered list of up to CAPACITY signed 32-bit entries and accepts one
// insert, delete or read request per clock cycle; busy stays low. The result
// of a request appears on the cycle after it is taken, marked by done, and is
// present for that one cycle only, since the receiver cannot stall. Every cell
// of the row decides on its own whether to shift, load or hold, so the list is
// updated all at once whatever the position; a read collects the
// selected cell through an OR across the row.

module positional_ordered_list
	import pol_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [KIND_W-1:0]          kind,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [POS_W-1:0]           position,
	input  logic [SIDE_W-1:0]          placement,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_OUT_W-1:0]     entry_count,
	output logic signed [VALUE_W-1:0]  read_value
);

	localparam int CW = $clog2(CAPACITY + 1);

	cell_op_t            op;
	logic [CW-1:0]       idx;
	logic [STATUS_W-1:0] st;
	logic [CW-1:0]       count;
	logic [CW-1:0]       count_next;
	logic                req;

	logic [VALUE_W-1:0] cell_value [CAPACITY];
	logic [VALUE_W-1:0] cell_rd [CAPACITY];
	logic [VALUE_W-1:0] rd_or;

	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;
	logic [VALUE_W-1:0]     read_value_q;

	assign busy = 1'b0;
	assign req = start && !busy;

	pol_ctrl #(
		.CAPACITY(CAPACITY),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.kind(kind),
		.position(position),
		.placement(placement),
		.op(op),
		.idx(idx),
		.status(st),
		.count(count),
		.count_next(count_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_v;
		logic [VALUE_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end
		pol_cell #(
			.CW(CW),
			.IDX(CW'(i))
		) u_cell (
			.clk(clk),
			.op(op),
			.idx(idx),
			.load_value(value),
			.left_value(left_v),
			.right_value(right_v),
			.cur_value(cell_value[i]),
			.rd_word(cell_rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= st;
		entry_count_q <= COUNT_OUT_W'(count_next);
		read_value_q <= rd_or;
	end

	assign done = done_q;
	assign status = status_q;
	assign entry_count = entry_count_q;
	assign read_value = read_value_q;

	// Every accepted request gives exactly one result on the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req |=> done)
		else $error("accepted request gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!req |=> !done)
		else $error("result without a request");

	// A rejected request leaves the entry count untouched.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(req && st != ST_OK) |=> count == $past(count))
		else $error("rejected request changed the count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(CAPACITY) >= count)
		else $error("entry count above capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> read_value == '0)
		else $error("failed request returned data");

endmodule
